>>> rtl/fdtd_1d_free_space_step_macros.svh
// ----------------------------------------------------------------------------
// FDTD assertion macros
// Shared concurrent assertion forms for the FDTD step block.
// ----------------------------------------------------------------------------
`ifndef FDTD_1D_FREE_SPACE_STEP_MACROS_SVH
`define FDTD_1D_FREE_SPACE_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDTD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("FDTD assertion failed");

// Next-cycle implication, disabled during reset.
`define FDTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("FDTD assertion failed");

`endif

>>> rtl/fdtd_pkg.sv
// ----------------------------------------------------------------------------
// FDTD package
// Types and constants shared by the FDTD grid modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fdtd_pkg;

   localparam int DEFAULT_CELLS       = 256;
   localparam int DEFAULT_FIELD_WIDTH = 16;

   localparam int COUNT_W  = 9;
   localparam int SOURCE_W = 8;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd200;
   localparam logic [SOURCE_W-1:0] SOURCE_RESET = 8'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_COUNT  = 1'b0,
      CSR_SOURCE_CELL = 1'b1
   } fdtd_csr_type;

   typedef enum logic {
      FUNC_STEP = 1'b0,
      FUNC_READ = 1'b1
   } fdtd_func_type;

   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] source_value;
      logic [INDEX_W-1:0]        cell_index;
   } fdtd_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] e_value;
      logic signed [VALUE_W-1:0] h_value;
   } fdtd_rsp_type;

   typedef struct packed {
      logic                e_phase;
      logic                h_phase;
      logic [COUNT_W-1:0]  count;
      logic [SOURCE_W-1:0] source;
   } fdtd_cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/fdtd_cell.sv
// ----------------------------------------------------------------------------
// FDTD grid cell
// Holds the E and H values of one grid point and updates them from its
// neighbors in the E phase and the H phase of a time step, or loads the pulse into E at the source cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtd_cell
   import fdtd_pkg::*;
#(
   parameter int FIELD_WIDTH = DEFAULT_FIELD_WIDTH,
   parameter int INDEX       = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire fdtd_cell_ctrl_type       ctrl,
   input  wire logic signed [FIELD_WIDTH-1:0] pulse,
   input  wire logic signed [FIELD_WIDTH-1:0] h_left,
   input  wire logic signed [FIELD_WIDTH-1:0] e_right,
   output logic signed [FIELD_WIDTH-1:0]      e_value,
   output logic signed [FIELD_WIDTH-1:0]      h_value
);

   localparam logic signed [FIELD_WIDTH:0] MAX_V = (FIELD_WIDTH+1)'((1 << (FIELD_WIDTH-1)) - 1);
   localparam logic signed [FIELD_WIDTH:0] MIN_V = -MAX_V - (FIELD_WIDTH+1)'(1);

   logic signed [FIELD_WIDTH-1:0] e_ff, e_in;
   logic signed [FIELD_WIDTH-1:0] h_ff, h_in;
   logic signed [FIELD_WIDTH:0]   e_diff, e_sum, h_diff, h_sum;
   logic signed [FIELD_WIDTH-1:0] e_half, h_half;
   logic                          e_upd, e_force, h_upd;

   function automatic logic signed [FIELD_WIDTH-1:0] sat(input logic signed [FIELD_WIDTH:0] v);
      if (v > MAX_V) begin
         return MAX_V[FIELD_WIDTH-1:0];
      end else if (v < MIN_V) begin
         return MIN_V[FIELD_WIDTH-1:0];
      end
      return v[FIELD_WIDTH-1:0];
   endfunction

   assign e_diff = (FIELD_WIDTH+1)'(h_left) - (FIELD_WIDTH+1)'(h_ff);
   assign e_half = e_diff[FIELD_WIDTH:1];
   assign e_sum  = (FIELD_WIDTH+1)'(e_ff) + (FIELD_WIDTH+1)'(e_half);

   assign h_diff = (FIELD_WIDTH+1)'(e_ff) - (FIELD_WIDTH+1)'(e_right);
   assign h_half = h_diff[FIELD_WIDTH:1];
   assign h_sum  = (FIELD_WIDTH+1)'(h_ff) + (FIELD_WIDTH+1)'(h_half);

   assign e_force = ctrl.e_phase && (int'(ctrl.source) == INDEX);
   assign e_upd   = ctrl.e_phase && (INDEX >= 1) && (INDEX < int'(ctrl.count));
   assign h_upd   = ctrl.h_phase && (INDEX + 1 < int'(ctrl.count));

   always_comb begin
      e_in = e_ff;
      h_in = h_ff;
      if (e_force) begin
         e_in = pulse;
      end else if (e_upd) begin
         e_in = sat(e_sum);
      end
      if (h_upd) begin
         h_in = sat(h_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
         h_ff <= '0;
      end else begin
         e_ff <= e_in;
         h_ff <= h_in;
      end
   end

   assign e_value = e_ff;
   assign h_value = h_ff;

endmodule

`default_nettype wire

>>> rtl/fdtd_rdtree.sv
// ----------------------------------------------------------------------------
// FDTD read select
// Two-level select of one cell's E and H values; the first level selects
// within each group of cells into registers, the second selects the group.
// ----------------------------------------------------------------------------
`default_nettype none

module fdtd_rdtree
   import fdtd_pkg::*;
#(
   parameter int CELLS       = DEFAULT_CELLS,
   parameter int FIELD_WIDTH = DEFAULT_FIELD_WIDTH
) (
   input  wire                                clock,
   input  wire                                load,
   input  wire logic [$clog2(CELLS)-1:0]      addr,
   input  wire logic signed [FIELD_WIDTH-1:0] e_cells [CELLS],
   input  wire logic signed [FIELD_WIDTH-1:0] h_cells [CELLS],
   output logic signed [FIELD_WIDTH-1:0]      e_sel,
   output logic signed [FIELD_WIDTH-1:0]      h_sel
);

   localparam int ADDR_W = $clog2(CELLS);
   localparam int GRP_W  = ADDR_W / 2;
   localparam int GS     = 1 << GRP_W;
   localparam int NG     = (CELLS + GS - 1) / GS;

   logic signed [FIELD_WIDTH-1:0] e_grp_ff [NG];
   logic signed [FIELD_WIDTH-1:0] h_grp_ff [NG];
   logic signed [FIELD_WIDTH-1:0] e_grp_in [NG];
   logic signed [FIELD_WIDTH-1:0] h_grp_in [NG];
   logic [GRP_W-1:0]              lo_addr;
   logic [ADDR_W-GRP_W-1:0]       hi_addr;

   assign lo_addr = addr[GRP_W-1:0];
   assign hi_addr = addr[ADDR_W-1:GRP_W];

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         e_grp_in[g] = '0;
         h_grp_in[g] = '0;
         for (int j = 0; j < GS; j++) begin
            if ((g * GS + j < CELLS) && (lo_addr == GRP_W'(j))) begin
               e_grp_in[g] = e_cells[g * GS + j];
               h_grp_in[g] = h_cells[g * GS + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         e_grp_ff <= e_grp_in;
         h_grp_ff <= h_grp_in;
      end
   end

   always_comb begin
      e_sel = '0;
      h_sel = '0;
      for (int g = 0; g < NG; g++) begin
         if (hi_addr == (ADDR_W-GRP_W)'(g)) begin
            e_sel = e_grp_ff[g];
            h_sel = h_grp_ff[g];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/fdtd_1d_free_space_step.sv
// ----------------------------------------------------------------------------
// One-dimensional free-space FDTD step
// A row of grid cells holding E and H in signed fixed point, advanced one
// time step per step command, with single-cell readout.
// ----------------------------------------------------------------------------
// After the transfer at start, every command passes through phase A and then
// phase B: a step updates all E cells at once in the first and all H cells at
// once in the second; a read goes through the two levels of the registered
// cell select. busy is high only in phase A, so a new command may follow in
// phase B. The result appears on rsp_payload with rsp_valid high for one
// cycle, the cycle after the second one, and must be taken then; a step
// returns zeros. The receiver cannot stall the block. Configuration writes are
// always ready and must only be made while no command is in progress.
`default_nettype none

`include "fdtd_1d_free_space_step_macros.svh"

module fdtd_1d_free_space_step
   import fdtd_pkg::*;
#(
   parameter int CELLS       = DEFAULT_CELLS,
   parameter int FIELD_WIDTH = DEFAULT_FIELD_WIDTH
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire fdtd_req_type           req_payload,
   output logic                        rsp_valid,
   output fdtd_rsp_type                rsp_payload,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(CELLS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PHASE_A,
      S_PHASE_B
   } state_type;

   state_type          state_ff, state_in;
   fdtd_req_type       req_ff;
   logic               rsp_valid_ff;
   fdtd_rsp_type       rsp_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SOURCE_W-1:0] source_ff;

   logic                          accept;
   logic                          is_read;
   logic                          idx_ok;
   logic [ADDR_W-1:0]             rd_addr;
   fdtd_cell_ctrl_type            ctrl;
   logic signed [FIELD_WIDTH-1:0] pulse;
   logic signed [FIELD_WIDTH-1:0] e_cells [CELLS];
   logic signed [FIELD_WIDTH-1:0] h_cells [CELLS];
   logic signed [FIELD_WIDTH-1:0] e_sel, h_sel;
   fdtd_rsp_type                  rsp_in;

   assign busy      = (state_ff == S_PHASE_A);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign is_read   = (req_ff.func == FUNC_READ);
   assign idx_ok    = (int'(req_ff.cell_index) < CELLS);
   assign rd_addr   = ADDR_W'(req_ff.cell_index);

   generate
      if (FIELD_WIDTH >= VALUE_W) begin : g_pulse_ext
         assign pulse = FIELD_WIDTH'(req_ff.source_value);
      end else begin : g_pulse_sat
         localparam logic signed [VALUE_W-1:0] P_MAX = VALUE_W'((1 << (FIELD_WIDTH-1)) - 1);
         localparam logic signed [VALUE_W-1:0] P_MIN = -P_MAX - VALUE_W'(1);
         always_comb begin
            if (req_ff.source_value > P_MAX) begin
               pulse = P_MAX[FIELD_WIDTH-1:0];
            end else if (req_ff.source_value < P_MIN) begin
               pulse = P_MIN[FIELD_WIDTH-1:0];
            end else begin
               pulse = req_ff.source_value[FIELD_WIDTH-1:0];
            end
         end
      end
   endgenerate

   always_comb begin
      ctrl.e_phase = (state_ff == S_PHASE_A) && !is_read;
      ctrl.h_phase = (state_ff == S_PHASE_B) && !is_read;
      ctrl.count   = (int'(count_ff) > CELLS) ? COUNT_W'(CELLS) : count_ff;
      ctrl.source  = source_ff;
   end

   generate
      for (genvar k = 0; k < CELLS; k++) begin : g_cell
         logic signed [FIELD_WIDTH-1:0] h_left, e_right;
         if (k == 0) begin : g_first
            assign h_left = '0;
         end else begin : g_mid_l
            assign h_left = h_cells[k-1];
         end
         if (k == CELLS - 1) begin : g_last
            assign e_right = '0;
         end else begin : g_mid_r
            assign e_right = e_cells[k+1];
         end
         fdtd_cell #(
            .FIELD_WIDTH(FIELD_WIDTH),
            .INDEX      (k)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .pulse  (pulse),
            .h_left (h_left),
            .e_right(e_right),
            .e_value(e_cells[k]),
            .h_value(h_cells[k])
         );
      end
   endgenerate

   fdtd_rdtree #(
      .CELLS      (CELLS),
      .FIELD_WIDTH(FIELD_WIDTH)
   ) u_rdtree (
      .clock  (clock),
      .load   ((state_ff == S_PHASE_A) && is_read),
      .addr   (rd_addr),
      .e_cells(e_cells),
      .h_cells(h_cells),
      .e_sel  (e_sel),
      .h_sel  (h_sel)
   );

   always_comb begin
      rsp_in = '0;
      if (is_read && idx_ok) begin
         rsp_in.e_value = VALUE_W'(e_sel);
         rsp_in.h_value = VALUE_W'(h_sel);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PHASE_A;
            end
         end
         S_PHASE_A: begin
            state_in = S_PHASE_B;
         end
         S_PHASE_B: begin
            state_in = accept ? S_PHASE_A : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_PHASE_B);
      end
      if (state_ff == S_PHASE_B) begin
         rsp_ff <= rsp_in;
      end
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         source_ff <= SOURCE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELL_COUNT:  count_ff  <= csr_data;
            CSR_SOURCE_CELL: source_ff <= csr_data[SOURCE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FDTD_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `FDTD_ASSERT_NEXT(a_busy_one_cycle, clock, reset, busy, !busy)
   `FDTD_ASSERT_NEXT(a_result_after_b, clock, reset, state_ff == S_PHASE_B, rsp_valid)
   `FDTD_ASSERT_NEXT(a_step_zero, clock, reset, (state_ff == S_PHASE_B) && !is_read, rsp_payload == '0)
   `FDTD_ASSERT_IMPL(a_valid_source, clock, reset, rsp_valid, $past(state_ff) == S_PHASE_B)

endmodule

`default_nettype wire

>>> test/fdtd_1d_free_space_step_checker.sv
// ----------------------------------------------------------------------------
// FDTD step checker
// Watches the command, result and register channels of the FDTD step block,
// keeps its own copy of the E and H rows and the register settings, works out
// the result of every accepted command and compares each result with the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module fdtd_1d_free_space_step_checker
   import fdtd_pkg::*;
#(
   parameter int CELLS = DEFAULT_CELLS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire                        busy,
   input  fdtd_req_type               req_payload,
   input  wire                        rsp_valid,
   input  fdtd_rsp_type               rsp_payload,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         failures,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_MAX = (1 << (VALUE_W - 1)) - 1;
   localparam int FIELD_MIN = -(1 << (VALUE_W - 1));

   logic signed [VALUE_W-1:0] e_cells [CELLS];
   logic signed [VALUE_W-1:0] h_cells [CELLS];
   logic [COUNT_W-1:0]        cell_count;
   logic [SOURCE_W-1:0]       source_cell;
   fdtd_rsp_type              awaited_fields [$];
   int                        mismatch_count = 0;
   int                        outstanding = 0;

   assign failures = mismatch_count;
   assign pending  = outstanding;

   function automatic logic signed [VALUE_W-1:0] clamp(input int sum);
      if (sum > FIELD_MAX) begin
         return VALUE_W'(FIELD_MAX);
      end
      if (sum < FIELD_MIN) begin
         return VALUE_W'(FIELD_MIN);
      end
      return VALUE_W'(sum);
   endfunction

   // E is updated from the old H row, then the source is forced, then H is
   // updated from the new E row. The arithmetic shift halves toward minus
   // infinity.
   function automatic void advance_grid(input logic signed [VALUE_W-1:0] pulse);
      int span;
      span = (cell_count > CELLS) ? CELLS : int'(cell_count);
      for (int k = 1; k < span; k++) begin
         e_cells[k] = clamp(int'(e_cells[k]) +
                            ((int'(h_cells[k-1]) - int'(h_cells[k])) >>> 1));
      end
      if (source_cell < CELLS) begin
         e_cells[source_cell] = pulse;
      end
      for (int k = 0; k + 1 < span; k++) begin
         h_cells[k] = clamp(int'(h_cells[k]) +
                            ((int'(e_cells[k]) - int'(e_cells[k+1])) >>> 1));
      end
   endfunction

   always @(posedge clock) begin
      fdtd_rsp_type want;
      fdtd_rsp_type oldest;
      if (reset) begin
         for (int k = 0; k < CELLS; k++) begin
            e_cells[k] = '0;
            h_cells[k] = '0;
         end
         cell_count  = COUNT_RESET;
         source_cell = SOURCE_RESET;
         awaited_fields.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (fdtd_csr_type'(csr_index))
               CSR_CELL_COUNT: begin
                  cell_count = csr_data[COUNT_W-1:0];
               end
               CSR_SOURCE_CELL: begin
                  source_cell = csr_data[SOURCE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            want = '0;
            if (req_payload.func == FUNC_STEP) begin
               advance_grid(req_payload.source_value);
            end else if (req_payload.cell_index < CELLS) begin
               want.e_value = e_cells[req_payload.cell_index];
               want.h_value = h_cells[req_payload.cell_index];
            end
            awaited_fields.push_back(want);
         end
         if (rsp_valid) begin
            if (awaited_fields.size() == 0) begin
               $display("%0t: result e_value %0d h_value %0d arrived with none awaited",
                        $realtime, rsp_payload.e_value, rsp_payload.h_value);
               mismatch_count++;
            end else begin
               oldest = awaited_fields.pop_front();
               if (rsp_payload.e_value !== oldest.e_value) begin
                  $display("%0t: e_value expected %0d, actual %0d",
                           $realtime, oldest.e_value, rsp_payload.e_value);
                  mismatch_count++;
               end
               if (rsp_payload.h_value !== oldest.h_value) begin
                  $display("%0t: h_value expected %0d, actual %0d",
                           $realtime, oldest.h_value, rsp_payload.h_value);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = awaited_fields.size();
   end

endmodule

>>> test/fdtd_1d_free_space_step_tb.sv
// ----------------------------------------------------------------------------
// FDTD step testbench
// Drives step and read commands into the FDTD step block under a series of
// grid sizes and source positions, first a directed set around the field
// extremes and grid edges, then random commands, in most phases with random gaps. A separate
// checker predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module fdtd_1d_free_space_step_tb
   import fdtd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 400;
   localparam int SETTLE_TIME  = 4;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 42;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   fdtd_req_type          req_payload = '0;
   logic                  rsp_valid;
   fdtd_rsp_type          rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CELL_COUNT;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    failures;
   int                    pending;
   bit                    gaps_on = 1'b1;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   fdtd_1d_free_space_step dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   fdtd_1d_free_space_step_checker grid_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending)
   );

   function automatic logic signed [VALUE_W-1:0] random_pulse();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return '1;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic fdtd_req_type step_cmd(input logic signed [VALUE_W-1:0] pulse);
      fdtd_req_type item;
      item.func         = FUNC_STEP;
      item.source_value = pulse;
      item.cell_index   = INDEX_W'($urandom);
      return item;
   endfunction

   function automatic fdtd_req_type read_cmd(input logic [INDEX_W-1:0] where);
      fdtd_req_type item;
      item.func         = FUNC_READ;
      item.source_value = VALUE_W'($urandom);
      item.cell_index   = where;
      return item;
   endfunction

   // Called and left at a falling edge; the transfer happens at the first
   // rising edge with start high and busy low.
   task automatic issue(input fdtd_req_type item);
      int unsigned gap;
      gap = (gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_TIME) @(negedge clock);
   endtask

   task automatic write_registers(input logic [COUNT_W-1:0] span,
                                  input logic [SOURCE_W-1:0] src);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_CELL_COUNT;
      csr_data  <= CSR_DATA_W'(span);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_SOURCE_CELL;
      csr_data  <= CSR_DATA_W'(src);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0]  span;
      logic [SOURCE_W-1:0] src;
      int unsigned         top_cell;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset settings of 200 cells, source at 100.
      issue(read_cmd(8'd0));
      issue(read_cmd(8'd255));
      issue(step_cmd(16'sh7fff));
      issue(step_cmd(16'sh8000));
      issue(step_cmd(16'sh0001));
      issue(step_cmd(16'shffff));
      issue(read_cmd(8'd100));
      issue(read_cmd(8'd99));
      issue(read_cmd(8'd101));

      // An empty grid still forces the source cell.
      write_registers(9'd0, 8'd5);
      issue(step_cmd(16'sh3039));
      issue(read_cmd(8'd5));
      issue(read_cmd(8'd6));

      write_registers(9'd1, 8'd0);
      issue(step_cmd(16'sh8000));
      issue(read_cmd(8'd0));

      // A count beyond the row acts as the full row.
      write_registers(9'd511, 8'd255);
      issue(step_cmd(16'sh7fff));
      issue(step_cmd(16'sh7fff));
      issue(read_cmd(8'd255));
      issue(read_cmd(8'd254));

      write_registers(9'd2, 8'd1);
      issue(step_cmd(16'sh8000));
      issue(step_cmd(16'sh7fff));
      issue(read_cmd(8'd0));
      issue(read_cmd(8'd1));

      write_registers(9'd256, 8'd0);
      issue(step_cmd(16'sh5555));
      issue(read_cmd(8'd1));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               span = 9'd4;
               src  = 8'd0;
            end
            1: begin
               span = 9'd256;
               src  = 8'd255;
            end
            2: begin
               span = 9'd511;
               src  = 8'd128;
            end
            3: begin
               span = 9'd2;
               src  = 8'd1;
            end
            4: begin
               span = 9'd3;
               src  = 8'd200;
            end
            default: begin
               span = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 511))
                                                   : COUNT_W'($urandom_range(2, 24));
               top_cell = (span > 256) ? 255 : ((span == 0) ? 0 : span - 1);
               src = ($urandom_range(0, 3) == 0) ? SOURCE_W'($urandom_range(0, 255))
                                                  : SOURCE_W'($urandom_range(0, top_cell));
            end
         endcase
         top_cell = (span > 256) ? 255 : ((span == 0) ? 0 : span - 1);
         write_registers(span, src);
         gaps_on = (phase % 3 != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 6) begin
               issue(step_cmd(random_pulse()));
            end else if ($urandom_range(0, 3) == 0) begin
               issue(read_cmd(INDEX_W'($urandom)));
            end else begin
               issue(read_cmd(INDEX_W'($urandom_range(0, top_cell))));
            end
         end
      end

      settle();
      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("simulation failed");
      $finish;
   end

endmodule
